// ===== design/battery_level_estimator_defines.svh =====
// Assertion macros shared by the battery level estimator RTL.
`ifndef BATTERY_LEVEL_ESTIMATOR_DEFINES_SVH
`define BATTERY_LEVEL_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock outside reset.
`define BLE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("battery_level_estimator: same-cycle check failed");

// Next-cycle implication, checked on every rising clock outside reset.
`define BLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("battery_level_estimator: next-cycle check failed");

`endif

// ===== design/ble_pkg.sv =====
// Package with types and constants of the battery level estimator.
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

   // Field and state widths
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 22;
   localparam int CNT_W      = 7;
   localparam int LVL_W      = 14;
   localparam int MV_W       = 16;
   localparam int PCT_W      = 7;
   localparam int SPAN_W     = 5;
   localparam int PCT_PROD_W = SPAN_W + LVL_W;
   localparam int CSR_IDX_W  = 3;

   // Register reset values in millivolts
   localparam logic [LVL_W-1:0] RST_ADC_OFFSET   = 14'd0;
   localparam logic [LVL_W-1:0] RST_LEVEL_MIN    = 14'd3000;
   localparam logic [LVL_W-1:0] RST_LEVEL_TEN    = 14'd3500;
   localparam logic [LVL_W-1:0] RST_LEVEL_TWENTY = 14'd3600;
   localparam logic [LVL_W-1:0] RST_LEVEL_FIFTY  = 14'd3750;
   localparam logic [LVL_W-1:0] RST_LEVEL_EIGHTY = 14'd3950;
   localparam logic [LVL_W-1:0] RST_LEVEL_MAX    = 14'd4200;

   // Charge curve break points in percent
   localparam logic [PCT_W-1:0] PCT_ZERO   = 7'd0;
   localparam logic [PCT_W-1:0] PCT_TEN    = 7'd10;
   localparam logic [PCT_W-1:0] PCT_TWENTY = 7'd20;
   localparam logic [PCT_W-1:0] PCT_FIFTY  = 7'd50;
   localparam logic [PCT_W-1:0] PCT_EIGHTY = 7'd80;
   localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;

   // Register indexes on the CSR port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ADC_OFFSET   = 3'd0,
      REG_LEVEL_MIN    = 3'd1,
      REG_LEVEL_TEN    = 3'd2,
      REG_LEVEL_TWENTY = 3'd3,
      REG_LEVEL_FIFTY  = 3'd4,
      REG_LEVEL_EIGHTY = 3'd5,
      REG_LEVEL_MAX    = 3'd6
   } reg_index_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG_LOAD,
      ST_AVG_DIV,
      ST_SCALE,
      ST_MV_DIV,
      ST_CLAMP,
      ST_SEGMENT,
      ST_PCT_MUL,
      ST_PCT_DIV,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== design/battery_level_estimator.sv =====
// Battery voltage and charge estimator built around one shared restoring divider.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  req     | in        | req_valid / req_stall | req_adc_sample
//  rsp     | out       | rsp_valid / rsp_stall | rsp_battery_mv, rsp_battery_percent
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// A request that only adds to the running sum leaves the sequencer idle.
// The request that completes the average runs the shared divider up to three times
// (SUM_W, DVD_W and PCT_PROD_W steps, one quotient bit per cycle); the last division
// is skipped when the percent settles on a segment end.
// req_stall is high while the sequencer runs; a result waiting on rsp_stall
// holds in the output register and blocks only the next finished result.
// Reset is synchronous, active high, restores the control and configuration registers and clears the sum.
`timescale 1ns / 1ps
`default_nettype none

`include "battery_level_estimator_defines.svh"

module battery_level_estimator #(
   parameter int AVG_SAMPLES = 8,
   parameter int DIVIDER_R1  = 1000,
   parameter int DIVIDER_R2  = 1000
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [ble_pkg::SAMPLE_W-1:0] req_adc_sample,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ble_pkg::MV_W-1:0]             rsp_battery_mv,
   output logic [ble_pkg::PCT_W-1:0]            rsp_battery_percent,
   // register write channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ble_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ble_pkg::LVL_W-1:0]       csr_data
);

   // Derived sizes of the scaling and the shared divider
   localparam int SCALE   = DIVIDER_R1 + DIVIDER_R2;
   localparam int DIVR2   = (DIVIDER_R2 == 0) ? 1 : DIVIDER_R2;
   localparam int SCALE_W = $clog2(SCALE + 1);
   localparam int AVG_W   = $clog2(AVG_SAMPLES + 1);
   localparam int R2_W    = $clog2(DIVR2 + 1);
   localparam int DVD_W   = ble_pkg::SUM_W + SCALE_W;
   localparam int DVS_A   = (AVG_W > ble_pkg::LVL_W) ? AVG_W : ble_pkg::LVL_W;
   localparam int DVS_W   = (R2_W > DVS_A) ? R2_W : DVS_A;
   localparam int STEP_W  = $clog2(DVD_W + 1);
   localparam logic [SCALE_W-1:0] SCALE_C = SCALE_W'(SCALE);

   // Control state
   ble_pkg::state_type              state_ff, state_in;
   logic [ble_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [ble_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // Configuration registers
   logic [ble_pkg::LVL_W-1:0] offset_ff, lvl_min_ff, lvl_ten_ff, lvl_twenty_ff;
   logic [ble_pkg::LVL_W-1:0] lvl_fifty_ff, lvl_eighty_ff, lvl_max_ff;

   // Shared divider registers
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Working registers of the percent path
   logic [ble_pkg::MV_W-1:0]  mv_ff, mv_in;
   logic [ble_pkg::LVL_W-1:0] v_ff, v_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [ble_pkg::PCT_W-1:0] p0_ff, p0_in, p1_ff, p1_in, pct_ff, pct_in;

   // Output registers
   logic [ble_pkg::MV_W-1:0]  rsp_mv_ff, rsp_mv_in;
   logic [ble_pkg::PCT_W-1:0] rsp_pct_ff, rsp_pct_in;

   // Combinational helpers
   logic                         req_take, rsp_take;
   logic [ble_pkg::SUM_W-1:0]    sample_ext, mag, base;
   logic [DVS_W:0]               div_shl;
   logic                         div_ge;
   logic [DVS_W-1:0]             div_rem;
   logic [DVD_W-1:0]             div_dvd;
   logic [DVD_W-1:0]             scaled;
   logic [ble_pkg::MV_W-1:0]     mv_sat, v_low;
   logic [ble_pkg::SPAN_W-1:0]   span;
   logic [ble_pkg::LVL_W-1:0]    rise;
   logic [ble_pkg::PCT_PROD_W-1:0] pct_prod;

   assign req_stall = (state_ff != ble_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_battery_mv      = rsp_mv_ff;
   assign rsp_battery_percent = rsp_pct_ff;

   // Sign-extend the sample into the sum width
   assign sample_ext = {{(ble_pkg::SUM_W - ble_pkg::SAMPLE_W){req_adc_sample[ble_pkg::SAMPLE_W-1]}},
                        req_adc_sample};

   // Magnitude of the captured sum
   assign mag = dvd_ff[ble_pkg::SUM_W-1] ? (~dvd_ff[ble_pkg::SUM_W-1:0] + 1'b1)
                                         : dvd_ff[ble_pkg::SUM_W-1:0];

   // One restoring division step
   assign div_shl = {rem_ff, dvd_ff[DVD_W-1]};
   assign div_ge  = (div_shl >= {1'b0, dvs_ff});
   assign div_rem = div_ge ? DVS_W'(div_shl - {1'b0, dvs_ff}) : div_shl[DVS_W-1:0];
   assign div_dvd = {dvd_ff[DVD_W-2:0], div_ge};

   // Offset and divider-ratio scaling of the average
   assign base   = dvd_ff[ble_pkg::SUM_W-1:0] + ble_pkg::SUM_W'(offset_ff);
   assign scaled = DVD_W'(base * SCALE_C);

   // Saturate the voltage and clamp it into the level range
   assign mv_sat = (|dvd_ff[DVD_W-1:ble_pkg::MV_W]) ? '1 : dvd_ff[ble_pkg::MV_W-1:0];
   assign v_low  = (mv_sat < ble_pkg::MV_W'(lvl_min_ff)) ? ble_pkg::MV_W'(lvl_min_ff) : mv_sat;

   // Interpolation numerator
   assign span     = ble_pkg::SPAN_W'(p1_ff - p0_ff);
   assign rise     = v_ff - lo_ff;
   assign pct_prod = span * rise;

   // Next state and datapath loads
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      mv_in        = mv_ff;
      v_in         = v_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      pct_in       = pct_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;

      case (state_ff)
         ble_pkg::ST_IDLE: begin
            // Accumulate; hand the completed sum to the sequencer
            if (req_take) begin
               if (count_ff + 1'b1 >= ble_pkg::CNT_W'(AVG_SAMPLES)) begin
                  dvd_in   = DVD_W'(sum_ff + sample_ext);
                  sum_in   = '0;
                  count_in = '0;
                  state_in = ble_pkg::ST_AVG_LOAD;
               end else begin
                  sum_in   = sum_ff + sample_ext;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ble_pkg::ST_AVG_LOAD: begin
            // Divide the magnitude by the sample count
            dvd_in   = DVD_W'(mag) << (DVD_W - ble_pkg::SUM_W);
            dvs_in   = DVS_W'(AVG_SAMPLES);
            rem_in   = '0;
            step_in  = STEP_W'(ble_pkg::SUM_W);
            state_in = ble_pkg::ST_AVG_DIV;
         end
         ble_pkg::ST_AVG_DIV: begin
            dvd_in  = div_dvd;
            rem_in  = div_rem;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = ble_pkg::ST_SCALE;
            end
         end
         ble_pkg::ST_SCALE: begin
            // Scale by R1+R2, then divide by R2
            dvd_in   = scaled;
            dvs_in   = DVS_W'(DIVR2);
            rem_in   = '0;
            step_in  = STEP_W'(DVD_W);
            state_in = ble_pkg::ST_MV_DIV;
         end
         ble_pkg::ST_MV_DIV: begin
            dvd_in  = div_dvd;
            rem_in  = div_rem;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = ble_pkg::ST_CLAMP;
            end
         end
         ble_pkg::ST_CLAMP: begin
            mv_in    = mv_sat;
            v_in     = (v_low > ble_pkg::MV_W'(lvl_max_ff)) ? lvl_max_ff
                                                            : v_low[ble_pkg::LVL_W-1:0];
            state_in = ble_pkg::ST_SEGMENT;
         end
         ble_pkg::ST_SEGMENT: begin
            // Pick the curve segment by threshold order
            if (v_ff < lvl_ten_ff) begin
               lo_in = lvl_min_ff;    hi_in = lvl_ten_ff;
               p0_in = ble_pkg::PCT_ZERO;   p1_in = ble_pkg::PCT_TEN;
            end else if (v_ff < lvl_twenty_ff) begin
               lo_in = lvl_ten_ff;    hi_in = lvl_twenty_ff;
               p0_in = ble_pkg::PCT_TEN;    p1_in = ble_pkg::PCT_TWENTY;
            end else if (v_ff < lvl_fifty_ff) begin
               lo_in = lvl_twenty_ff; hi_in = lvl_fifty_ff;
               p0_in = ble_pkg::PCT_TWENTY; p1_in = ble_pkg::PCT_FIFTY;
            end else if (v_ff < lvl_eighty_ff) begin
               lo_in = lvl_fifty_ff;  hi_in = lvl_eighty_ff;
               p0_in = ble_pkg::PCT_FIFTY;  p1_in = ble_pkg::PCT_EIGHTY;
            end else begin
               lo_in = lvl_eighty_ff; hi_in = lvl_max_ff;
               p0_in = ble_pkg::PCT_EIGHTY; p1_in = ble_pkg::PCT_FULL;
            end
            state_in = ble_pkg::ST_PCT_MUL;
         end
         ble_pkg::ST_PCT_MUL: begin
            // Settle the end points, else divide the numerator by the width
            if (hi_ff <= lo_ff || v_ff >= hi_ff) begin
               pct_in   = p1_ff;
               state_in = ble_pkg::ST_FINISH;
            end else if (v_ff <= lo_ff) begin
               pct_in   = p0_ff;
               state_in = ble_pkg::ST_FINISH;
            end else begin
               dvd_in   = DVD_W'(pct_prod) << (DVD_W - ble_pkg::PCT_PROD_W);
               dvs_in   = DVS_W'(hi_ff - lo_ff);
               rem_in   = '0;
               step_in  = STEP_W'(ble_pkg::PCT_PROD_W);
               state_in = ble_pkg::ST_PCT_DIV;
            end
         end
         ble_pkg::ST_PCT_DIV: begin
            dvd_in  = div_dvd;
            rem_in  = div_rem;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               pct_in   = p0_ff + div_dvd[ble_pkg::PCT_W-1:0];
               state_in = ble_pkg::ST_FINISH;
            end
         end
         ble_pkg::ST_FINISH: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_mv_in    = mv_ff;
               rsp_pct_in   = pct_ff;
               rsp_valid_in = 1'b1;
               state_in     = ble_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ble_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ble_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      dvd_ff     <= dvd_in;
      dvs_ff     <= dvs_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      mv_ff      <= mv_in;
      v_ff       <= v_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      pct_ff     <= pct_in;
      rsp_mv_ff  <= rsp_mv_in;
      rsp_pct_ff <= rsp_pct_in;
   end

   // Configuration writes; drop indexes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= ble_pkg::RST_ADC_OFFSET;
         lvl_min_ff    <= ble_pkg::RST_LEVEL_MIN;
         lvl_ten_ff    <= ble_pkg::RST_LEVEL_TEN;
         lvl_twenty_ff <= ble_pkg::RST_LEVEL_TWENTY;
         lvl_fifty_ff  <= ble_pkg::RST_LEVEL_FIFTY;
         lvl_eighty_ff <= ble_pkg::RST_LEVEL_EIGHTY;
         lvl_max_ff    <= ble_pkg::RST_LEVEL_MAX;
      end else if (csr_valid && csr_ready) begin
         case (ble_pkg::reg_index_type'(csr_index))
            ble_pkg::REG_ADC_OFFSET:   offset_ff     <= csr_data;
            ble_pkg::REG_LEVEL_MIN:    lvl_min_ff    <= csr_data;
            ble_pkg::REG_LEVEL_TEN:    lvl_ten_ff    <= csr_data;
            ble_pkg::REG_LEVEL_TWENTY: lvl_twenty_ff <= csr_data;
            ble_pkg::REG_LEVEL_FIFTY:  lvl_fifty_ff  <= csr_data;
            ble_pkg::REG_LEVEL_EIGHTY: lvl_eighty_ff <= csr_data;
            ble_pkg::REG_LEVEL_MAX:    lvl_max_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Assertions
   `BLE_ASSERT_NOW(a_count_below_avg, 1'b1, count_ff < ble_pkg::CNT_W'(AVG_SAMPLES))
   `BLE_ASSERT_NOW(a_percent_range, rsp_valid_ff, rsp_pct_ff <= ble_pkg::PCT_FULL)
   `BLE_ASSERT_NOW(a_div_step_live,
      state_ff == ble_pkg::ST_AVG_DIV || state_ff == ble_pkg::ST_MV_DIV ||
      state_ff == ble_pkg::ST_PCT_DIV, step_ff != '0)
   `BLE_ASSERT_NEXT(a_finish_waits,
      state_ff == ble_pkg::ST_FINISH && rsp_valid_ff && rsp_stall,
      state_ff == ble_pkg::ST_FINISH)

endmodule

`default_nettype wire
